>>> rtl/core/rmpt_pkg.sv
// ---------------------------------------------------------------------------
// rmpt_pkg
// Shared widths, register codes, status codes and operation codes for the MSI page table core.
// ---------------------------------------------------------------------------
package rmpt_pkg;

	localparam int PAGE_SHIFT        = 12;
	localparam int ADDR_W            = 56;
	localparam int PPN_W             = 44;
	localparam int GRP_W             = 7;
	localparam int IDX_W             = PPN_W + GRP_W;
	localparam int TOP_W             = $clog2(PPN_W + 1);
	localparam int PTE_W             = 64;
	localparam int ENTRY_IDX_W       = 10;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_ADDR_W        = 5;
	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int COUNT_WIDTH_DEF   = 16;

	localparam logic [1:0] FLAT_MODE = 2'd3;

	typedef enum logic [1:0] {
		REG_ADDR_MASK   = 2'd0,
		REG_GROUP_BITS  = 2'd1,
		REG_GROUP_SHIFT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_UNUSED = 2'd2
	} status_t;

	typedef enum logic {
		OP_MAP   = 1'b0,
		OP_UNMAP = 1'b1
	} op_t;

endpackage

>>> rtl/core/rmpt_if.sv
// ---------------------------------------------------------------------------
// rmpt_if
// Request and response channels of the MSI page table core.
// ---------------------------------------------------------------------------
interface rmpt_req_if;
	import rmpt_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [ADDR_W-1:0] msi_addr;
	logic [ADDR_W-1:0] target_addr;

	modport source (output valid, output operation, output msi_addr, output target_addr,
		input ready);
	modport sink (input valid, input operation, input msi_addr, input target_addr,
		output ready);
endinterface

interface rmpt_rsp_if;
	import rmpt_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [ENTRY_IDX_W-1:0] entry_index;
	logic [1:0]             status;
	logic                   pte_written;
	logic [PTE_W-1:0]       pte_value;
	logic                   invalidate;
	logic [ADDR_W-1:0]      invalidate_addr;

	modport source (output valid, output entry_index, output status, output pte_written,
		output pte_value, output invalidate, output invalidate_addr, input ready);
	modport sink (input valid, input entry_index, input status, input pte_written,
		input pte_value, input invalidate, input invalidate_addr, output ready);
endinterface

>>> rtl/core/rmpt_ram.sv
// ---------------------------------------------------------------------------
// rmpt_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module rmpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/refcounted_msi_page_table_core.sv
// ---------------------------------------------------------------------------
// refcounted_msi_page_table_core
// Reference-counted flat MSI page table: map/unmap requests against one RAM.
// ---------------------------------------------------------------------------
// In the accept cycle the core computes the table index and reads the entry
// word (use count plus page number) from a single RAM; in the busy state that
// follows it updates the word, writes it back and loads the response register.
// The RAM sees one read and at most one write per request, and the core takes
// no new request until the last one has left the busy state. A request
// waits in the busy state while an earlier response has not been taken. After
// reset the core sweeps the table to zero, one entry per cycle, before it takes
// the first request; register writes are taken throughout. The cycle after a
// register write takes no request while the derived index masks settle.
// ---------------------------------------------------------------------------
module refcounted_msi_page_table_core #(
	parameter int TABLE_ENTRIES = rmpt_pkg::TABLE_ENTRIES_DEF,
	parameter int COUNT_WIDTH   = rmpt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rmpt_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rmpt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rmpt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	rmpt_req_if.sink                        req,
	rmpt_rsp_if.source                      rsp
);
	import rmpt_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int MW = COUNT_WIDTH + PPN_W;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_BUSY  = 3'b100
	} state_t;

	// register port
	logic [PPN_W-1:0] addr_mask_q;
	logic [2:0]       group_bits_q;
	logic [5:0]       group_shift_q;
	logic             cfg_wr;
	logic             cfg_wr_q;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_mask_q   <= '0;
			group_bits_q  <= '0;
			group_shift_q <= 6'd24;
			cfg_wr_q      <= 1'b0;
		end else begin
			cfg_wr_q <= cfg_wr;
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_ADDR_MASK:   addr_mask_q   <= pwdata[PPN_W-1:0];
					REG_GROUP_BITS:  group_bits_q  <= pwdata[2:0];
					REG_GROUP_SHIFT: group_shift_q <= pwdata[5:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ADDR_MASK:   prdata = {{(CFG_DATA_W-PPN_W){1'b0}}, addr_mask_q};
			REG_GROUP_BITS:  prdata = {{(CFG_DATA_W-3){1'b0}}, group_bits_q};
			REG_GROUP_SHIFT: prdata = {{(CFG_DATA_W-6){1'b0}}, group_shift_q};
			default:         prdata = '0;
		endcase
	end

	// derived index masks, refreshed every cycle from the registers
	logic [GRP_W-1:0] gmask_c, gmask_q;
	logic [5:0]       gs_c, gs_q;
	logic [IDX_W-1:0] gfield_c;
	logic [PPN_W-1:0] rmask_c, rmask_q;
	logic [TOP_W-1:0] top_c, top_q;

	always_comb begin
		gmask_c  = (GRP_W'(1) << group_bits_q) - GRP_W'(1);
		gs_c     = (group_shift_q >= 6'(PAGE_SHIFT)) ? group_shift_q - 6'(PAGE_SHIFT) : '0;
		gfield_c = {{(IDX_W-GRP_W){1'b0}}, gmask_c} << gs_c;
		rmask_c  = addr_mask_q & ~gfield_c[PPN_W-1:0];
		top_c    = '0;
		for (int i = 0; i < PPN_W; i++) begin
			if (rmask_c[i]) begin
				top_c = TOP_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		gmask_q <= gmask_c;
		gs_q    <= gs_c;
		rmask_q <= rmask_c;
		top_q   <= top_c;
	end

	// index of the incoming request
	logic [PPN_W-1:0] page_c;
	logic [PPN_W-1:0] page_sh_c;
	logic [GRP_W-1:0] group_c;
	logic [IDX_W-1:0] idx_c;
	logic             in_range_c;

	always_comb begin
		page_c     = req.msi_addr[ADDR_W-1:PAGE_SHIFT];
		page_sh_c  = page_c >> gs_q;
		group_c    = page_sh_c[GRP_W-1:0] & gmask_q;
		idx_c      = {{GRP_W{1'b0}}, page_c & rmask_q}
			| ({{PPN_W{1'b0}}, group_c} << top_q);
		in_range_c = idx_c < IDX_W'(TABLE_ENTRIES);
	end

	// control
	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic          accept;
	logic          done;
	logic          rsp_valid_q;

	assign req.ready = (state_q == S_IDLE) && !cfg_wr_q;
	assign accept    = req.valid & req.ready;
	assign done      = (state_q == S_BUSY) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_BUSY;
					end
				end
				S_BUSY: begin
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// request fields held for the update cycle
	logic             op_s1;
	logic [PPN_W-1:0] tgt_ppn_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             in_range_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= req.operation;
			tgt_ppn_s1  <= req.target_addr[ADDR_W-1:PAGE_SHIFT];
			idx_s1      <= idx_c;
			in_range_s1 <= in_range_c;
		end
	end

	// table word: {use count, page number}
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [MW-1:0] ram_wdata;
	logic [MW-1:0] ram_rdata;

	rmpt_ram #(
		.WIDTH(MW),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(idx_c[AW-1:0]),
		.rdata(ram_rdata)
	);

	// read-modify-write of the entry
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [PPN_W-1:0]       ppn_rd;
	logic                   upd_c;
	logic [MW-1:0]          upd_word_c;
	status_t                st_c;
	logic                   written_c;
	logic [PTE_W-1:0]       value_c;
	logic                   inval_c;
	logic [ADDR_W-1:0]      iaddr_c;

	assign cnt_rd = ram_rdata[MW-1:PPN_W];
	assign ppn_rd = ram_rdata[PPN_W-1:0];

	always_comb begin
		upd_c      = 1'b0;
		upd_word_c = ram_rdata;
		st_c       = ST_OK;
		written_c  = 1'b0;
		value_c    = '0;
		inval_c    = 1'b0;
		iaddr_c    = '0;
		if (!in_range_s1) begin
			st_c = ST_RANGE;
		end else if (op_s1 == OP_MAP) begin
			if (cnt_rd == '0) begin
				upd_c      = 1'b1;
				upd_word_c = {COUNT_WIDTH'(1), tgt_ppn_s1};
				written_c  = 1'b1;
				value_c    = {{(PTE_W-PPN_W-10){1'b0}}, tgt_ppn_s1, 7'b0, FLAT_MODE, 1'b1};
				inval_c    = 1'b1;
				iaddr_c    = {tgt_ppn_s1, {PAGE_SHIFT{1'b0}}};
			end else if (cnt_rd != {COUNT_WIDTH{1'b1}}) begin
				// saturate at the top count
				upd_c      = 1'b1;
				upd_word_c = {cnt_rd + COUNT_WIDTH'(1), ppn_rd};
			end
		end else begin
			if (cnt_rd == '0) begin
				st_c = ST_UNUSED;
			end else begin
				upd_c      = 1'b1;
				upd_word_c = {cnt_rd - COUNT_WIDTH'(1), ppn_rd};
				if (cnt_rd == COUNT_WIDTH'(1)) begin
					// last reference gone: drop the entry, invalidate the old page
					written_c = 1'b1;
					inval_c   = 1'b1;
					iaddr_c   = {ppn_rd, {PAGE_SHIFT{1'b0}}};
				end
			end
		end
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = done & upd_c;
			ram_waddr = idx_s1[AW-1:0];
			ram_wdata = upd_word_c;
		end
	end

	// response register
	logic [ENTRY_IDX_W-1:0] entry_index_q;
	status_t                status_q;
	logic                   pte_written_q;
	logic [PTE_W-1:0]       pte_value_q;
	logic                   invalidate_q;
	logic [ADDR_W-1:0]      invalidate_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			entry_index_q     <= idx_s1[ENTRY_IDX_W-1:0];
			status_q          <= st_c;
			pte_written_q     <= written_c;
			pte_value_q       <= value_c;
			invalidate_q      <= inval_c;
			invalidate_addr_q <= iaddr_c;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.entry_index     = entry_index_q;
	assign rsp.status          = status_q;
	assign rsp.pte_written     = pte_written_q;
	assign rsp.pte_value       = pte_value_q;
	assign rsp.invalidate      = invalidate_q;
	assign rsp.invalidate_addr = invalidate_addr_q;

	// checks
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == S_BUSY) |-> in_range_s1)
		else $error("table write for an out-of-range index");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_BUSY))
		else $error("response beat raised without an update cycle");

	a_write_inval: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.pte_written) |-> rsp.invalidate)
		else $error("entry written without an invalidate");

	a_err_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (!rsp.pte_written && !rsp.invalidate))
		else $error("failed request reports a table change");

	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !(req.valid && req.ready))
		else $error("request taken before derived masks settled");

endmodule

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the refcounted MSI page table core. Requests go in
// through a bursty sender and responses come back through a receiver that
// stalls on its own pattern. A shadow copy of the table, the use counts and
// the registers predicts every response beat. The checker compares each beat
// field by field in order. Directed checks cover the reset values of the
// registers, flat and grouped indexing, range and unused-entry errors, and a
// use-count ramp up and back down past zero. Random phases then stress
// map/unmap traffic under several register settings.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rmpt_pkg::*;

	localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
	localparam int COUNT_WIDTH   = COUNT_WIDTH_DEF;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [PPN_W-1:0]       MASK_ALL  = '1;
	localparam logic [ADDR_W-1:0]      ADDR_ALL  = '1;
	localparam int LIMIT_CYCLES  = 2_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 72;
	localparam int POOL_SIZE     = 6;
	localparam int RAMP_MAPS     = 24;

	typedef struct packed {
		logic [ENTRY_IDX_W-1:0] entry_index;
		status_t                status;
		logic                   pte_written;
		logic [PTE_W-1:0]       pte_value;
		logic                   invalidate;
		logic [ADDR_W-1:0]      invalidate_addr;
	} page_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	rmpt_req_if req_bus ();
	rmpt_rsp_if rsp_bus ();

	refcounted_msi_page_table_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// shadow of the registers and of the table
	logic [PPN_W-1:0]       cfg_addr_mask;
	logic [2:0]             cfg_group_bits;
	logic [5:0]             cfg_group_shift;
	logic [PTE_W-1:0]       pte_shadow [TABLE_ENTRIES];
	logic [COUNT_WIDTH-1:0] use_shadow [TABLE_ENTRIES];

	page_result_t pending_results [$];

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned results_checked = 0;
	int unsigned requests_sent = 0;
	int unsigned table_writes = 0;
	int unsigned table_clears = 0;
	int unsigned range_errors = 0;
	int unsigned unused_unmaps = 0;
	int unsigned saturated_maps = 0;

	bit          sender_idle_en = 1'b1;
	bit          rsp_stall_en = 1'b1;
	int unsigned burst_left = 0;
	int unsigned ready_run = 0;
	int unsigned stall_run = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
				pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void note_failure(string what, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
	endfunction

	function automatic logic [ADDR_W-1:0] random_addr();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	function automatic logic [ADDR_W-1:0] msi_for_page(logic [PPN_W-1:0] page);
		return {page, 12'($urandom)};
	endfunction

	function automatic logic [63:0] table_index_of(logic [ADDR_W-1:0] msi);
		logic [63:0] page;
		logic [63:0] mask;
		logic [63:0] gmask;
		logic [63:0] grp;
		int          gs;
		int          top;
		int          i;
		page = 64'(msi[ADDR_W-1:PAGE_SHIFT]);
		mask = 64'(cfg_addr_mask);
		if (cfg_group_bits == 3'd0)
			return page & mask;
		gmask = (64'd1 << cfg_group_bits) - 64'd1;
		// shifts below the page offset take the group from page bit zero
		gs = (cfg_group_shift >= PAGE_SHIFT) ? int'(cfg_group_shift) - PAGE_SHIFT : 0;
		grp = (page >> gs) & gmask;
		mask = mask & ~(gmask << gs);
		top = 0;
		for (i = 0; i < PPN_W; i++)
			if (mask[i])
				top = i + 1;
		return (page & mask) | (grp << top);
	endfunction

	function automatic page_result_t apply_page_request(op_t op, logic [ADDR_W-1:0] msi,
		logic [ADDR_W-1:0] tgt);
		page_result_t     r;
		logic [63:0]      idx;
		logic [PPN_W-1:0] ppn;
		int               e;
		r = '0;
		idx = table_index_of(msi);
		r.entry_index = idx[ENTRY_IDX_W-1:0];
		r.status = ST_OK;
		if (idx >= TABLE_ENTRIES) begin
			r.status = ST_RANGE;
			range_errors++;
			return r;
		end
		e = int'(idx);
		if (op == OP_MAP) begin
			if (use_shadow[e] == '0) begin
				ppn = tgt[ADDR_W-1:PAGE_SHIFT];
				r.pte_value = {10'd0, ppn, 7'd0, FLAT_MODE, 1'b1};
				r.pte_written = 1'b1;
				r.invalidate = 1'b1;
				r.invalidate_addr = {ppn, 12'h000};
				pte_shadow[e] = r.pte_value;
				use_shadow[e] = COUNT_WIDTH'(1);
				table_writes++;
			end else if (use_shadow[e] != COUNT_MAX) begin
				use_shadow[e] = use_shadow[e] + COUNT_WIDTH'(1);
			end else begin
				saturated_maps++;
			end
		end else if (use_shadow[e] == '0) begin
			r.status = ST_UNUSED;
			unused_unmaps++;
		end else begin
			use_shadow[e] = use_shadow[e] - COUNT_WIDTH'(1);
			if (use_shadow[e] == '0) begin
				// invalidate the page the entry held, then clear it
				r.pte_written = 1'b1;
				r.invalidate = 1'b1;
				r.invalidate_addr = {pte_shadow[e][53:10], 12'h000};
				pte_shadow[e] = '0;
				table_clears++;
			end
		end
		return r;
	endfunction

	// receiver: alternate random runs of ready and stall
	always @(posedge clk) begin
		if (!rsp_stall_en) begin
			rsp_bus.ready <= 1'b1;
		end else if (ready_run != 0) begin
			ready_run--;
			rsp_bus.ready <= 1'b1;
		end else if (stall_run != 0) begin
			stall_run--;
			rsp_bus.ready <= 1'b0;
		end else begin
			ready_run = $urandom_range(0, 8);
			stall_run = $urandom_range(1, 6);
			rsp_bus.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		page_result_t want;
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				note_failure("response beat with nothing pending", '0,
					64'(rsp_bus.entry_index));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (rsp_bus.entry_index !== want.entry_index)
					note_failure("entry_index", 64'(want.entry_index),
						64'(rsp_bus.entry_index));
				if (rsp_bus.status !== want.status)
					note_failure("status", 64'(want.status), 64'(rsp_bus.status));
				if (rsp_bus.pte_written !== want.pte_written)
					note_failure("pte_written", 64'(want.pte_written),
						64'(rsp_bus.pte_written));
				if (rsp_bus.pte_value !== want.pte_value)
					note_failure("pte_value", want.pte_value, rsp_bus.pte_value);
				if (rsp_bus.invalidate !== want.invalidate)
					note_failure("invalidate", 64'(want.invalidate),
						64'(rsp_bus.invalidate));
				if (rsp_bus.invalidate_addr !== want.invalidate_addr)
					note_failure("invalidate_addr", 64'(want.invalidate_addr),
						64'(rsp_bus.invalidate_addr));
			end
		end
	end

	task automatic apb_transfer(bit write, reg_idx_t r, logic [CFG_DATA_W-1:0] wdata,
		output logic [CFG_DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {r, 3'b000};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_register(reg_idx_t r);
		logic [CFG_DATA_W-1:0] got;
		logic [CFG_DATA_W-1:0] want;
		apb_transfer(1'b0, r, '0, got);
		case (r)
			REG_ADDR_MASK:  want = 64'(cfg_addr_mask);
			REG_GROUP_BITS: want = 64'(cfg_group_bits);
			default:        want = 64'(cfg_group_shift);
		endcase
		if (got !== want)
			note_failure($sformatf("readback of %s", r.name()), want, got);
	endtask

	task automatic write_register(reg_idx_t r, logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] discard;
		apb_transfer(1'b1, r, value, discard);
		case (r)
			REG_ADDR_MASK:  cfg_addr_mask = value[PPN_W-1:0];
			REG_GROUP_BITS: cfg_group_bits = value[2:0];
			default:        cfg_group_shift = value[5:0];
		endcase
		check_register(r);
	endtask

	// write all three registers, sometimes with junk above the field
	task automatic configure(logic [PPN_W-1:0] mask, logic [2:0] gbits, logic [5:0] gshift);
		logic [CFG_DATA_W-1:0] junk;
		junk = '0;
		if ($urandom_range(0, 1))
			junk = {$urandom, $urandom};
		write_register(REG_ADDR_MASK, {junk[CFG_DATA_W-1:PPN_W], mask});
		write_register(REG_GROUP_BITS, {junk[CFG_DATA_W-1:3], gbits});
		write_register(REG_GROUP_SHIFT, {junk[CFG_DATA_W-1:6], gshift});
	endtask

	task automatic send_request(op_t op, logic [ADDR_W-1:0] msi, logic [ADDR_W-1:0] tgt);
		if (sender_idle_en && burst_left == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		req_bus.valid <= 1'b1;
		req_bus.operation <= op;
		req_bus.msi_addr <= msi;
		req_bus.target_addr <= tgt;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		pending_results.push_back(apply_page_request(op, msi, tgt));
		requests_sent++;
		if (burst_left != 0)
			burst_left--;
	endtask

	// drop valid, drain the responses, let the core settle
	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_register_reset();
		check_register(REG_ADDR_MASK);
		check_register(REG_GROUP_BITS);
		check_register(REG_GROUP_SHIFT);
	endtask

	task automatic test_flat_indexing();
		configure(44'h3FF, 3'd0, 6'd24);
		send_request(OP_MAP, msi_for_page(44'h0), ADDR_ALL);
		send_request(OP_MAP, msi_for_page(44'h0), '0);
		send_request(OP_UNMAP, msi_for_page(44'h0), ADDR_ALL);
		send_request(OP_UNMAP, msi_for_page(44'h0), random_addr());
		send_request(OP_UNMAP, msi_for_page(44'h0), random_addr());
		send_request(OP_MAP, ADDR_ALL, '0);
		send_request(OP_UNMAP, ADDR_ALL, ADDR_ALL);
		send_request(OP_MAP, msi_for_page(44'h5), random_addr());
		wait_idle();
		configure(MASK_ALL, 3'd0, 6'd24);
		send_request(OP_MAP, ADDR_ALL, random_addr());
		send_request(OP_UNMAP, ADDR_ALL, random_addr());
		send_request(OP_MAP, msi_for_page(44'h3FF), random_addr());
		send_request(OP_MAP, msi_for_page(44'h400), random_addr());
		wait_idle();
	endtask

	task automatic test_group_indexing();
		configure(44'hFF, 3'd3, 6'd24);
		send_request(OP_MAP, msi_for_page(44'h3012), random_addr());
		send_request(OP_MAP, msi_for_page(44'h4012), random_addr());
		wait_idle();
		// shift below the page offset: group comes from page bit zero
		configure(44'h3FF, 3'd7, 6'd0);
		send_request(OP_MAP, msi_for_page(44'h280), random_addr());
		send_request(OP_MAP, msi_for_page(44'h281), random_addr());
		wait_idle();
		configure('0, 3'd7, 6'd63);
		send_request(OP_MAP, msi_for_page(44'hABCDE), random_addr());
		wait_idle();
		configure('0, 3'd7, 6'd12);
		send_request(OP_MAP, msi_for_page(44'h7F), random_addr());
		send_request(OP_MAP, ADDR_ALL, random_addr());
		send_request(OP_UNMAP, msi_for_page(44'h7F), random_addr());
		send_request(OP_UNMAP, msi_for_page(44'h7F), random_addr());
		wait_idle();
		configure(MASK_ALL, 3'd7, 6'd55);
		send_request(OP_MAP, msi_for_page(44'hAB), random_addr());
		send_request(OP_MAP, msi_for_page({1'b1, 43'h5}), random_addr());
		wait_idle();
	endtask

	task automatic test_count_ramp();
		logic [ADDR_W-1:0] msi;
		int                i;
		configure(44'h3FF, 3'd0, 6'd24);
		sender_idle_en = 1'b0;
		rsp_stall_en = 1'b0;
		msi = random_addr();
		msi[ADDR_W-1:PAGE_SHIFT+10] = '0;
		// map one entry repeatedly, then unmap back down to zero and once more
		for (i = 0; i < RAMP_MAPS; i++)
			send_request(OP_MAP, msi, random_addr());
		for (i = 0; i <= RAMP_MAPS; i++)
			send_request(OP_UNMAP, msi, random_addr());
		wait_idle();
	endtask

	task automatic test_random_traffic();
		logic [ADDR_W-1:0] pool [POOL_SIZE];
		logic [ADDR_W-1:0] cand;
		int                phase;
		int                slot;
		int                n;
		int                tries;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: configure(44'h3FF, 3'd0, 6'd24);
				1: configure(MASK_ALL, 3'd7, 6'd55);
				2: configure('0, 3'd7, 6'd12);
				3: configure(PPN_W'($urandom_range(0, 1023)), 3'($urandom_range(1, 7)),
					6'($urandom_range(0, 11)));
				4: configure(PPN_W'({$urandom, $urandom}), 3'($urandom),
					6'($urandom_range(12, 55)));
				default: configure(PPN_W'($urandom_range(0, 1023)), 3'($urandom),
					6'($urandom_range(12, 55)));
			endcase
			sender_idle_en = (phase % 3 != 2);
			rsp_stall_en = (phase % 3 != 1);
			// pick POOL_SIZE pages, retried for an in-range index, so counts rise and fall back to zero
			for (slot = 0; slot < POOL_SIZE; slot++) begin
				tries = 0;
				do begin
					cand = random_addr();
					if ($urandom_range(0, 1))
						cand[ADDR_W-1:PAGE_SHIFT+10] = '0;
					tries++;
				end while (table_index_of(cand) >= TABLE_ENTRIES && tries < 64);
				pool[slot] = cand;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_request(op_t'($urandom_range(0, 1)), random_addr(), random_addr());
				end else begin
					slot = $urandom_range(0, POOL_SIZE - 1);
					send_request(($urandom_range(0, 99) < 55) ? OP_MAP : OP_UNMAP, pool[slot],
						random_addr());
				end
			end
			wait_idle();
		end
	endtask

	initial begin
		cfg_addr_mask = '0;
		cfg_group_bits = '0;
		cfg_group_shift = 6'd24;
		foreach (pte_shadow[i]) begin
			pte_shadow[i] = '0;
			use_shadow[i] = '0;
		end
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_bus.valid <= 1'b0;
		req_bus.operation <= OP_MAP;
		req_bus.msi_addr <= '0;
		req_bus.target_addr <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_register_reset();
		test_flat_indexing();
		test_group_indexing();
		test_count_ramp();
		test_random_traffic();

		$display("covered %0d requests: %0d entry writes, %0d clears, %0d maps at the count limit",
			requests_sent, table_writes, table_clears, saturated_maps);
		$display("%0d out-of-range indexes, %0d unmaps of unused entries, %0d responses checked",
			range_errors, unused_unmaps, results_checked);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> refcounted_msi_page_table_core.f
rtl/core/rmpt_pkg.sv
rtl/core/rmpt_if.sv
rtl/core/rmpt_ram.sv
rtl/core/refcounted_msi_page_table_core.sv
verif/testbench.sv
